@@ rtl/core/drq_pkg.sv @@
// Package for the disk request task-file block: types, codes and constants.
// Used by every module under rtl/core; depends on nothing.
package drq_pkg;
	localparam int Drives = 2;
	localparam int SlotsPerDrive = 5;
	localparam int NSlots = Drives * SlotsPerDrive;
	localparam int MaxRetries = 7;
	localparam logic [7:0] WinRead = 8'h20;
	localparam logic [7:0] DevBase = 8'hA0;
	localparam logic [7:0] StatMask = 8'hF1;
	localparam logic [7:0] StatGood = 8'h50;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_READ = 2'd1,
		REQ_STATUS = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		EV_REG = 3'd0,
		EV_REJECT = 3'd1,
		EV_MORE = 3'd2,
		EV_DONE = 3'd3,
		EV_FAIL = 3'd4,
		EV_FAULT = 3'd5
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV1,
		ST_DIV2,
		ST_EMIT,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_slot;
		logic load_req;
		logic status_pass;
		logic status_fail;
		logic start_div1;
		logic start_div2;
		logic div_step;
		logic emit_clr;
		logic emit_next;
		logic set_await;
		logic clr_await;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_bad;
		logic geo_bad;
		logic head_bad;
		logic div_done;
		logic emit_last;
		logic awaiting;
		logic remain_one;
		logic err_limit;
	} sts_t;
endpackage

@@ rtl/core/drq_datapath.sv @@
// Datapath: partition table, request registers, shared bit-serial divider and
// task-file byte selection. Depends on drq_pkg.
module drq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  drq_pkg::cmd_t      cmd,
	output drq_pkg::sts_t      sts,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [3:0]         slot_index,
	input  logic [31:0]        slot_start,
	input  logic [31:0]        slot_length,
	input  logic [3:0]         minor_device,
	input  logic [31:0]        start_sector,
	input  logic [7:0]         sector_count,
	output logic [3:0]         emit_sel,
	output logic [7:0]         emit_data
);
	import drq_pkg::*;

	logic [7:0] spt_q [Drives];
	logic [4:0] heads_q [Drives];
	logic [15:0] precomp_q [Drives];
	logic [7:0] ctl_q [Drives];
	logic [31:0] pstart_q [NSlots];
	logic [31:0] plen_q [NSlots];
	logic [NSlots-1:0] pvalid_q;
	logic [3:0] slot_q;
	logic [31:0] sector_q;
	logic [7:0] remain_q;
	logic [2:0] errors_q;
	logic await_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [7:0] divisor_q;
	logic [5:0] cnt_q;
	logic [7:0] secno_q;
	logic [2:0] emit_q;

	logic slot_ok;
	logic [3:0] sidx;
	logic drive;
	logic [31:0] len_sel;
	logic [31:0] start_sel;
	logic [32:0] trial;

	assign slot_ok = slot_q < 4'(NSlots);
	assign sidx = slot_ok ? slot_q : 4'd0;
	assign drive = (Drives > 1) && (slot_q >= 4'(SlotsPerDrive));
	assign len_sel = (slot_ok && pvalid_q[sidx]) ? plen_q[sidx] : 32'd0;
	assign start_sel = (slot_ok && pvalid_q[sidx]) ? pstart_q[sidx] : 32'd0;
	assign trial = {rem_q, quo_q[31]} - {25'd0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < Drives; d++) begin
				spt_q[d] <= 8'd17;
				heads_q[d] <= 5'd4;
				precomp_q[d] <= 16'd0;
				ctl_q[d] <= 8'd0;
			end
			pvalid_q <= '0;
			slot_q <= '0;
			sector_q <= '0;
			remain_q <= '0;
			errors_q <= '0;
			await_q <= 1'b0;
			cnt_q <= '0;
			emit_q <= '0;
		end else begin
			if (cfg_valid && (int'(cfg_index[2]) < Drives)) begin
				unique case (cfg_index[1:0])
					2'd0: spt_q[cfg_index[2]] <= cfg_data[7:0];
					2'd1: heads_q[cfg_index[2]] <= cfg_data[4:0];
					2'd2: precomp_q[cfg_index[2]] <= cfg_data;
					default: ctl_q[cfg_index[2]] <= cfg_data[7:0];
				endcase
			end
			if (cmd.load_slot && slot_index < 4'(NSlots))
				pvalid_q[slot_index] <= 1'b1;
			if (cmd.load_req) begin
				slot_q <= minor_device;
				sector_q <= start_sector;
				remain_q <= sector_count;
				errors_q <= '0;
			end
			if (cmd.status_pass) begin
				errors_q <= '0;
				sector_q <= sector_q + 32'd1;
				remain_q <= remain_q - 8'd1;
			end
			if (cmd.status_fail)
				errors_q <= errors_q + 3'd1;
			if (cmd.set_await)
				await_q <= 1'b1;
			if (cmd.clr_await)
				await_q <= 1'b0;
			if (cmd.start_div1 || cmd.start_div2)
				cnt_q <= 6'd32;
			else if (cmd.div_step)
				cnt_q <= cnt_q - 6'd1;
			if (cmd.emit_clr)
				emit_q <= '0;
			else if (cmd.emit_next)
				emit_q <= emit_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_slot && slot_index < 4'(NSlots)) begin
			pstart_q[slot_index] <= slot_start;
			plen_q[slot_index] <= slot_length;
		end
		if (cmd.start_div1) begin
			quo_q <= sector_q + start_sel;
			rem_q <= '0;
			divisor_q <= spt_q[drive];
		end else if (cmd.start_div2) begin
			secno_q <= rem_q[7:0] + 8'd1;
			quo_q <= quo_q;
			rem_q <= '0;
			divisor_q <= {3'd0, heads_q[drive]};
		end else if (cmd.div_step) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		sts.range_bad = !slot_ok || (remain_q == 8'd0) ||
			({1'b0, sector_q} + 33'd2 > {1'b0, len_sel});
		sts.geo_bad = (spt_q[drive] == 8'd0) || (heads_q[drive] == 5'd0);
		sts.head_bad = rem_q > 32'd15;
		sts.div_done = cnt_q == 6'd0;
		sts.emit_last = emit_q == 3'd7;
		sts.awaiting = await_q;
		sts.remain_one = remain_q == 8'd1;
		sts.err_limit = (errors_q + 3'd1) >= 3'(MaxRetries);
	end

	assign emit_sel = {1'b0, emit_q};
	always_comb begin
		case (emit_q)
			3'd0: emit_data = ctl_q[drive];
			3'd1: emit_data = precomp_q[drive][9:2];
			3'd2: emit_data = remain_q;
			3'd3: emit_data = secno_q;
			3'd4: emit_data = quo_q[7:0];
			3'd5: emit_data = quo_q[15:8];
			3'd6: emit_data = DevBase | {3'd0, drive, rem_q[3:0]};
			default: emit_data = WinRead;
		endcase
	end
endmodule

@@ rtl/core/drq_ctrl.sv @@
// Controller state machine: sequences checks, the two divisions and the output items.
// Depends on drq_pkg.
module drq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [7:0]         status_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_res,
	output logic               emit_sel_use,
	output logic               last,
	output drq_pkg::cmd_t      cmd,
	input  drq_pkg::sts_t      sts
);
	import drq_pkg::*;

	state_t state_q, state_d;
	ev_t ev_q, ev_d;
	logic fire;

	assign fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ev_q <= EV_REJECT;
		end else begin
			state_q <= state_d;
			ev_q <= ev_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ev_d = ev_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					unique case (req_t'(req_type))
						REQ_READ: state_d = ST_CHECK;
						REQ_STATUS: begin
							if (sts.awaiting) begin
								if ((status_byte & StatMask) == StatGood) begin
									state_d = ST_RESULT;
									ev_d = sts.remain_one ? EV_DONE : EV_MORE;
								end else if (sts.err_limit) begin
									state_d = ST_RESULT;
									ev_d = EV_FAIL;
								end else begin
									state_d = ST_CHECK;
								end
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHECK: begin
				if (sts.range_bad) begin
					state_d = ST_RESULT;
					ev_d = EV_REJECT;
				end else if (sts.geo_bad) begin
					state_d = ST_RESULT;
					ev_d = EV_FAULT;
				end else begin
					state_d = ST_DIV1;
				end
			end
			ST_DIV1: if (sts.div_done) state_d = ST_DIV2;
			ST_DIV2: begin
				if (sts.div_done) begin
					if (sts.head_bad) begin
						state_d = ST_RESULT;
						ev_d = EV_FAULT;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: if (out_ready && sts.emit_last) state_d = ST_IDLE;
			ST_RESULT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = state_q == ST_IDLE;
		out_valid = (state_q == ST_EMIT) || (state_q == ST_RESULT);
		event_res = (state_q == ST_EMIT) ? EV_REG : ev_q;
		emit_sel_use = state_q == ST_EMIT;
		last = (state_q == ST_RESULT) || sts.emit_last;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_slot = fire && req_t'(req_type) == REQ_LOAD;
				cmd.load_req = fire && req_t'(req_type) == REQ_READ;
				cmd.status_pass = fire && req_t'(req_type) == REQ_STATUS && sts.awaiting &&
					((status_byte & StatMask) == StatGood);
				cmd.status_fail = fire && req_t'(req_type) == REQ_STATUS && sts.awaiting &&
					((status_byte & StatMask) != StatGood);
			end
			ST_CHECK: begin
				cmd.start_div1 = !sts.range_bad && !sts.geo_bad;
				cmd.emit_clr = 1'b1;
			end
			ST_DIV1: begin
				cmd.div_step = !sts.div_done;
				cmd.start_div2 = sts.div_done;
			end
			ST_DIV2: cmd.div_step = !sts.div_done;
			ST_EMIT: begin
				cmd.emit_next = out_ready;
				cmd.set_await = 1'b1;
			end
			ST_RESULT: cmd.clr_await = ev_q != EV_MORE;
			default: cmd = '0;
		endcase
	end
endmodule

@@ rtl/core/disk_request_chs_task_file.sv @@
// Top level of the disk request task-file block: joins controller and datapath.
// Depends on drq_pkg, drq_ctrl and drq_datapath.
//
//   channel   direction  handshake              payload
//   in        into       in_valid / in_ready     req_type .. status_byte
//   out       out of     out_valid / out_ready   event_res, reg_select, reg_data, last
//   cfg       into       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A read or retry passes the check and then two divisions in one shared shift-subtract
// unit before its eight items, which leave one a cycle while out is ready.
// A completion that passes or fails for good gives one item in the next cycle.
// Reset clears all control state and the partition table valid bits; stalls on out hold it.
module disk_request_chs_task_file (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  slot_index,
	input  logic [31:0] slot_start,
	input  logic [31:0] slot_length,
	input  logic [3:0]  minor_device,
	input  logic [31:0] start_sector,
	input  logic [7:0]  sector_count,
	input  logic [7:0]  status_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [3:0]  reg_select,
	output logic [7:0]  reg_data,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import drq_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic use_emit;
	logic [3:0] emit_sel;
	logic [7:0] emit_data;

	assign cfg_ready = 1'b1;

	drq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .status_byte(status_byte), .out_valid(out_valid),
		.out_ready(out_ready), .event_res(event_res), .emit_sel_use(use_emit),
		.last(last), .cmd(cmd), .sts(sts)
	);

	drq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg_valid(cfg_valid),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .slot_index(slot_index),
		.slot_start(slot_start), .slot_length(slot_length), .minor_device(minor_device),
		.start_sector(start_sector), .sector_count(sector_count), .emit_sel(emit_sel),
		.emit_data(emit_data)
	);

	assign reg_select = use_emit ? emit_sel : 4'd0;
	assign reg_data = use_emit ? emit_data : 8'd0;
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the disk request task-file block (disk_request_chs_task_file).
// Predicts every result item from its own copy of the partition table, geometry and request state.
// Depends on drq_pkg and the RTL under rtl/core.
module testbench;
	import drq_pkg::*;

	typedef struct packed {
		logic [2:0] ev;
		logic [3:0] sel;
		logic [7:0] data;
		logic       lst;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = REQ_NONE;
	logic [3:0]  slot_index = '0;
	logic [31:0] slot_start = '0;
	logic [31:0] slot_length = '0;
	logic [3:0]  minor_device = '0;
	logic [31:0] start_sector = '0;
	logic [7:0]  sector_count = '0;
	logic [7:0]  status_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic [3:0]  reg_select;
	logic [7:0]  reg_data;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	disk_request_chs_task_file dut (.*);

	always #1 clk = ~clk;

	logic [7:0]  geo_spt [2];
	logic [4:0]  geo_heads [2];
	logic [15:0] geo_precomp [2];
	logic [7:0]  geo_ctl [2];
	logic [31:0] slot_base [NSlots];
	logic [31:0] slot_len [NSlots];
	logic [3:0]  req_slot;
	logic [31:0] req_sector;
	logic [7:0]  req_left;
	logic [2:0]  req_errors;
	logic        req_busy;
	res_t        expected_results [$];
	int          send_idle = 0;
	int          recv_stall = 0;
	int          quiet_cycles = 0;
	bit          failed = 0;

	task automatic finish_with(ev_t ev);
		req_busy = 0;
		expected_results.push_back({ev, 4'd0, 8'd0, 1'b1});
	endtask

	task automatic predict_issue();
		logic [31:0] abs_sec, track, cyl;
		logic [7:0] regs [8];
		int drv, hd;
		if (req_slot >= NSlots || {32'd0, req_sector} + 64'd2 > {32'd0, slot_len[req_slot]}) begin
			finish_with(EV_REJECT);
			return;
		end
		drv = req_slot / SlotsPerDrive;
		if (geo_spt[drv] == 0 || geo_heads[drv] == 0) begin
			finish_with(EV_FAULT);
			return;
		end
		abs_sec = req_sector + slot_base[req_slot];
		track = abs_sec / geo_spt[drv];
		hd = track % geo_heads[drv];
		cyl = track / geo_heads[drv];
		if (hd > 15) begin
			finish_with(EV_FAULT);
			return;
		end
		regs[0] = geo_ctl[drv];
		regs[1] = geo_precomp[drv][9:2];
		regs[2] = req_left;
		regs[3] = 8'(abs_sec % geo_spt[drv] + 1);
		regs[4] = cyl[7:0];
		regs[5] = cyl[15:8];
		regs[6] = DevBase | 8'(drv << 4) | 8'(hd);
		regs[7] = WinRead;
		for (int k = 0; k < 8; k++)
			expected_results.push_back({EV_REG, 4'(k), regs[k], k == 7});
		req_busy = 1;
	endtask

	task automatic predict_item(logic [1:0] t, logic [3:0] si, logic [31:0] ss, logic [31:0] sl,
			logic [3:0] md, logic [31:0] st, logic [7:0] sc, logic [7:0] sb);
		case (t)
			REQ_LOAD: if (si < NSlots) begin
				slot_base[si] = ss;
				slot_len[si] = sl;
			end
			REQ_READ: begin
				req_slot = md;
				req_sector = st;
				req_left = sc;
				req_errors = 0;
				if (sc == 0)
					finish_with(EV_REJECT);
				else
					predict_issue();
			end
			REQ_STATUS: if (req_busy) begin
				if ((sb & StatMask) == StatGood) begin
					req_errors = 0;
					req_sector++;
					req_left--;
					if (req_left != 0)
						expected_results.push_back({EV_MORE, 4'd0, 8'd0, 1'b1});
					else
						finish_with(EV_DONE);
				end else begin
					req_errors++;
					if (req_errors >= MaxRetries)
						finish_with(EV_FAIL);
					else
						predict_issue();
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(logic [1:0] t, logic [3:0] si, logic [31:0] ss, logic [31:0] sl,
			logic [3:0] md, logic [31:0] st, logic [7:0] sc, logic [7:0] sb);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		slot_index <= si;
		slot_start <= ss;
		slot_length <= sl;
		minor_device <= md;
		start_sector <= st;
		sector_count <= sc;
		status_byte <= sb;
		do @(posedge clk); while (!in_ready);
		predict_item(t, si, ss, sl, md, st, sc, sb);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= 3'(idx);
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx % 4)
			0: geo_spt[idx / 4] = val[7:0];
			1: geo_heads[idx / 4] = val[4:0];
			2: geo_precomp[idx / 4] = val;
			default: geo_ctl[idx / 4] = val[7:0];
		endcase
	endtask

	task automatic set_geometry(int d, int spt, int hds, logic [15:0] pc, logic [7:0] ctl);
		write_reg(4 * d, 16'(spt));
		write_reg(4 * d + 1, 16'(hds));
		write_reg(4 * d + 2, pc);
		write_reg(4 * d + 3, 16'(ctl));
	endtask

	task automatic send_load(int s, logic [31:0] b, logic [31:0] l);
		send_item(REQ_LOAD, 4'(s), b, l, '0, '0, '0, '0);
	endtask

	task automatic send_read(int m, logic [31:0] st, logic [7:0] sc);
		send_item(REQ_READ, 4'($urandom), $urandom, $urandom, 4'(m), st, sc, 8'($urandom));
	endtask

	task automatic send_status(logic [7:0] sb);
		send_item(REQ_STATUS, 4'($urandom), $urandom, $urandom, 4'($urandom), $urandom,
				8'($urandom), sb);
	endtask

	function automatic logic [7:0] random_status();
		if ($urandom_range(3) != 0)
			return (8'($urandom) & ~StatMask) | StatGood;
		return 8'($urandom);
	endfunction

	task automatic test_directed();
		send_status(StatGood);
		send_read(0, 32'd0, 8'd1);
		send_load(0, 32'd0, 32'hFFFF_FFFF);
		send_load(5, 32'hFFFF_FFF0, 32'd1000);
		send_load(12, 32'd5, 32'd5);
		send_load(3, 32'd100, 32'd2);
		send_read(0, 32'hFFFF_FFFD, 8'd2);
		send_status(StatGood);
		send_status(8'hFF);
		send_status(StatGood | 8'h0E);
		send_read(0, 32'hFFFF_FFFE, 8'd1);
		send_read(5, 32'd900, 8'd255);
		send_read(3, 32'd0, 8'd3);
		send_status(StatGood);
		send_status(8'h00);
		send_read(12, 32'd0, 8'd1);
		send_read(1, 32'd0, 8'd1);
		send_read(0, 32'd5, 8'd0);
		send_item(REQ_NONE, 4'hF, '1, '1, 4'hF, '1, '1, '1);
		send_read(0, 32'd1234, 8'd2);
		for (int k = 0; k < 7; k++)
			send_status(8'h51);
		wait_drained();
		set_geometry(0, 0, 16, 16'hFFFF, 8'hFF);
		send_read(0, 32'd7, 8'd1);
		wait_drained();
		set_geometry(0, 255, 0, 16'd0, 8'd0);
		send_read(0, 32'd7, 8'd1);
		wait_drained();
	endtask

	task automatic test_random(int n, int idle, int stall);
		int m;
		send_idle = idle;
		recv_stall = stall;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: send_load($urandom_range(15), $urandom, $urandom);
				1: send_item(2'($urandom_range(3)), 4'($urandom), $urandom, $urandom,
						4'($urandom), $urandom, 8'($urandom), 8'($urandom));
				2: send_status(random_status());
				default: begin
					m = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(9);
					if (m < NSlots && $urandom_range(1))
						send_load(m, $urandom, $urandom_range(1) ? '1 : $urandom);
					send_read(m, $urandom_range(3) ? $urandom_range(5000) : $urandom,
							8'($urandom_range(3) ? $urandom_range(1, 4) : $urandom));
					repeat ($urandom_range(1, 10)) send_status(random_status());
				end
			endcase
		end
		wait_drained();
	endtask

	initial begin
		for (int d = 0; d < 2; d++) begin
			geo_spt[d] = 17;
			geo_heads[d] = 4;
			geo_precomp[d] = 0;
			geo_ctl[d] = 0;
		end
		for (int s = 0; s < NSlots; s++) begin
			slot_base[s] = 0;
			slot_len[s] = 0;
		end
		req_slot = 0;
		req_sector = 0;
		req_left = 0;
		req_errors = 0;
		req_busy = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_geometry(0, 63, 16, 16'd300, 8'h08);
		set_geometry(1, 1, 1, 16'h1234, 8'h0A);
		test_random(14, 0, 0);
		set_geometry(1, 255, 16, 16'd0, 8'h00);
		test_random(14, 87, 0);
		set_geometry(0, 1, 16, 16'h8000, 8'h02);
		test_random(14, 0, 87);
		set_geometry(0, 17, 3, 16'd7, 8'h00);
		set_geometry(1, 9, 2, 16'd4, 8'h04);
		test_random(14, 34, 34);
		if (!failed)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (recv_stall > 0 && $urandom_range(99) < recv_stall)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result item with none expected: event_res %0d", event_res);
				failed = 1;
			end else begin
				exp_res = expected_results.pop_front();
				if (event_res !== exp_res.ev) begin
					$error("event_res expected %0d got %0d", exp_res.ev, event_res);
					failed = 1;
				end
				if (reg_select !== exp_res.sel) begin
					$error("reg_select expected %0d got %0d", exp_res.sel, reg_select);
					failed = 1;
				end
				if (reg_data !== exp_res.data) begin
					$error("reg_data expected %h got %h", exp_res.data, reg_data);
					failed = 1;
				end
				if (last !== exp_res.lst) begin
					$error("last expected %0d got %0d", exp_res.lst, last);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end
endmodule

@@ files.f @@
rtl/core/drq_pkg.sv
rtl/core/drq_datapath.sv
rtl/core/drq_ctrl.sv
rtl/core/disk_request_chs_task_file.sv
tb/sv/testbench.sv
